/* rtl/pwe_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register indexes and inter-stage records for the pulse evaluator.
// No dependencies; every other file of the block imports this package.
package pwe_pkg;

  localparam int TIME_BITS     = 32;
  localparam int LEVEL_BITS    = 32;
  localparam int CFG_DATA_BITS = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int S_DATA_BITS   = ((TIME_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS   = ((LEVEL_BITS + 7) / 8) * 8;
  localparam int PROD_BITS     = LEVEL_BITS + TIME_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOW_LEVEL     = 3'd0,
    REG_HIGH_LEVEL    = 3'd1,
    REG_START_DELAY   = 3'd2,
    REG_RISE_TIME     = 3'd3,
    REG_FALL_TIME     = 3'd4,
    REG_PULSE_WIDTH   = 3'd5,
    REG_PERIOD_LENGTH = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] low_level;
    logic [LEVEL_BITS-1:0] high_level;
    logic [TIME_BITS-1:0]  start_delay;
    logic [TIME_BITS-1:0]  rise_time;
    logic [TIME_BITS-1:0]  fall_time;
    logic [TIME_BITS-1:0]  pulse_width;
    logic [TIME_BITS-1:0]  period_length;
  } pwe_cfg_t;

  // Time since the delay, folded into one period.
  typedef struct packed {
    logic                 valid;
    logic                 past;
    logic [TIME_BITS-1:0] tau;
  } pwe_tau_t;

  // Result is from +/- floor(mag * num / den).
  typedef struct packed {
    logic                  valid;
    logic [LEVEL_BITS-1:0] from;
    logic                  up;
    logic [LEVEL_BITS-1:0] mag;
    logic [TIME_BITS-1:0]  num;
    logic [TIME_BITS-1:0]  den;
  } pwe_ramp_t;

  typedef struct packed {
    logic                  valid;
    logic [LEVEL_BITS-1:0] level;
  } pwe_lvl_t;

endpackage

/* rtl/pwe_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register bank of the pulse evaluator.
// Depends on pwe_pkg for the register indexes and the register record.
module pwe_cfg_regs import pwe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output pwe_cfg_t                 cfg_o
);

  pwe_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LOW_LEVEL:     cfg_d.low_level     = cfg_data_i[LEVEL_BITS-1:0];
        REG_HIGH_LEVEL:    cfg_d.high_level    = cfg_data_i[LEVEL_BITS-1:0];
        REG_START_DELAY:   cfg_d.start_delay   = cfg_data_i[TIME_BITS-1:0];
        REG_RISE_TIME:     cfg_d.rise_time     = cfg_data_i[TIME_BITS-1:0];
        REG_FALL_TIME:     cfg_d.fall_time     = cfg_data_i[TIME_BITS-1:0];
        REG_PULSE_WIDTH:   cfg_d.pulse_width   = cfg_data_i[TIME_BITS-1:0];
        REG_PERIOD_LENGTH: cfg_d.period_length = cfg_data_i[TIME_BITS-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/pwe_fold_pipe.sv */
`timescale 1ns / 1ps
// Entry stage and pipelined restoring remainder that folds time into one period.
// Depends on pwe_pkg; one remainder bit is resolved per stage.
module pwe_fold_pipe import pwe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  logic [TIME_BITS-1:0] time_i,
  input  pwe_cfg_t             cfg_i,
  output pwe_tau_t             tau_o
);

  logic                 v_q    [0:TIME_BITS];
  logic                 past_q [0:TIME_BITS];
  logic [TIME_BITS-1:0] x_q    [0:TIME_BITS];
  logic [TIME_BITS-1:0] rem_q  [1:TIME_BITS];
  logic [TIME_BITS-1:0] rem_d  [0:TIME_BITS-1];
  logic [TIME_BITS:0]   sh     [0:TIME_BITS-1];

  for (genvar k = 0; k < TIME_BITS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign sh[k] = {{TIME_BITS{1'b0}}, x_q[k][TIME_BITS-1-k]};
    end else begin : g_next
      assign sh[k] = {rem_q[k], x_q[k][TIME_BITS-1-k]};
    end
    assign rem_d[k] = (sh[k] >= {1'b0, cfg_i.period_length})
                      ? TIME_BITS'(sh[k] - {1'b0, cfg_i.period_length})
                      : sh[k][TIME_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= TIME_BITS; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= in_valid_i;
      for (int k = 0; k < TIME_BITS; k++) v_q[k+1] <= v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      past_q[0] <= time_i > cfg_i.start_delay;
      x_q[0]    <= time_i - cfg_i.start_delay;
      for (int k = 0; k < TIME_BITS; k++) begin
        past_q[k+1] <= past_q[k];
        x_q[k+1]    <= x_q[k];
        rem_q[k+1]  <= rem_d[k];
      end
    end
  end

  // With no period the time since the delay is used as it is.
  assign tau_o.valid = v_q[TIME_BITS];
  assign tau_o.past  = past_q[TIME_BITS];
  assign tau_o.tau   = (cfg_i.period_length == '0) ? x_q[TIME_BITS] : rem_q[TIME_BITS];

endmodule

/* rtl/pwe_seg_pipe.sv */
`timescale 1ns / 1ps
// Two stages that place the folded time in a segment and set up the ramp operands.
// Depends on pwe_pkg for the configuration and stage records.
module pwe_seg_pipe import pwe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  pwe_cfg_t cfg_i,
  input  pwe_tau_t tau_i,
  output pwe_ramp_t ramp_o
);

  // Stage A: bounds compared in parallel, level difference formed.
  logic                  a_valid_q;
  logic                  a_past_q, a_tau_zero_q, a_le_rise_q, a_le_rw_q, a_hi_ge_lo_q;
  logic [TIME_BITS-1:0]  a_tau_q, a_r_q;
  logic [LEVEL_BITS-1:0] a_mag_q;

  logic [TIME_BITS:0]    rw_sum;
  logic                  hi_ge_lo;

  assign rw_sum   = {1'b0, cfg_i.rise_time} + {1'b0, cfg_i.pulse_width};
  assign hi_ge_lo = $signed(cfg_i.high_level) >= $signed(cfg_i.low_level);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= tau_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_past_q     <= tau_i.past;
      a_tau_zero_q <= tau_i.tau == '0;
      a_le_rise_q  <= tau_i.tau <= cfg_i.rise_time;
      a_le_rw_q    <= {1'b0, tau_i.tau} <= rw_sum;
      a_tau_q      <= tau_i.tau;
      a_r_q        <= tau_i.tau - cfg_i.rise_time;
      a_hi_ge_lo_q <= hi_ge_lo;
      a_mag_q      <= hi_ge_lo ? cfg_i.high_level - cfg_i.low_level
                               : cfg_i.low_level - cfg_i.high_level;
    end
  end

  // Stage B: pick the segment. A held level is a ramp of zero magnitude.
  logic [TIME_BITS-1:0] r2;
  pwe_ramp_t            b_d, b_q;

  assign r2 = a_r_q - cfg_i.pulse_width;

  always_comb begin
    b_d.valid = a_valid_q;
    b_d.from  = cfg_i.low_level;
    b_d.up    = 1'b1;
    b_d.mag   = '0;
    b_d.num   = '0;
    b_d.den   = TIME_BITS'(1);
    priority if (!a_past_q || (a_tau_zero_q && cfg_i.rise_time == '0)) begin
      b_d.from = cfg_i.low_level;
    end else if (a_le_rise_q) begin
      b_d.from = cfg_i.low_level;
      b_d.up   = a_hi_ge_lo_q;
      b_d.mag  = a_mag_q;
      b_d.num  = a_tau_q;
      b_d.den  = cfg_i.rise_time;
    end else if (a_le_rw_q) begin
      b_d.from = cfg_i.high_level;
    end else if (r2 <= cfg_i.fall_time) begin
      b_d.from = cfg_i.high_level;
      b_d.up   = ~a_hi_ge_lo_q;
      b_d.mag  = a_mag_q;
      b_d.num  = r2;
      b_d.den  = cfg_i.fall_time;
    end else begin
      b_d.from = cfg_i.low_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (en_i) begin
      b_q <= b_d;
    end
  end

  assign ramp_o = b_q;

endmodule

/* rtl/pwe_ramp_div_pipe.sv */
`timescale 1ns / 1ps
// Ramp step: one multiply stage, a pipelined restoring divider, and the final add.
// Depends on pwe_pkg; one quotient bit is resolved per stage.
module pwe_ramp_div_pipe import pwe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  pwe_ramp_t ramp_i,
  output pwe_lvl_t  lvl_o
);

  // Index 0 is the multiply stage; index j+1 holds the result of divide step j.
  logic                  v_q    [0:LEVEL_BITS];
  logic [LEVEL_BITS-1:0] from_q [0:LEVEL_BITS];
  logic                  up_q   [0:LEVEL_BITS];
  logic [TIME_BITS-1:0]  den_q  [0:LEVEL_BITS-1];
  logic [LEVEL_BITS-1:0] lo_q   [0:LEVEL_BITS-1];
  logic [TIME_BITS-1:0]  rem_q  [0:LEVEL_BITS];
  logic [LEVEL_BITS-1:0] q_q    [1:LEVEL_BITS];

  logic [PROD_BITS-1:0]  prod;
  logic [TIME_BITS:0]    sh    [0:LEVEL_BITS-1];
  logic                  ge    [0:LEVEL_BITS-1];
  logic [TIME_BITS-1:0]  rem_d [0:LEVEL_BITS-1];
  logic [LEVEL_BITS-1:0] q_d   [0:LEVEL_BITS-1];

  // The quotient never exceeds the magnitude, so the upper product half is
  // already below the divisor and only LEVEL_BITS steps are needed.
  assign prod = PROD_BITS'(ramp_i.mag) * PROD_BITS'(ramp_i.num);

  for (genvar j = 0; j < LEVEL_BITS; j++) begin : g_step
    assign sh[j]    = {rem_q[j], lo_q[j][LEVEL_BITS-1-j]};
    assign ge[j]    = sh[j] >= {1'b0, den_q[j]};
    assign rem_d[j] = ge[j] ? TIME_BITS'(sh[j] - {1'b0, den_q[j]}) : sh[j][TIME_BITS-1:0];
    if (j == 0) begin : g_first
      assign q_d[j] = LEVEL_BITS'(ge[j]);
    end else begin : g_next
      assign q_d[j] = {q_q[j][LEVEL_BITS-2:0], ge[j]};
    end
  end

  logic                  f_valid_q;
  logic [LEVEL_BITS-1:0] f_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= LEVEL_BITS; j++) v_q[j] <= 1'b0;
      f_valid_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= ramp_i.valid;
      for (int j = 0; j < LEVEL_BITS; j++) v_q[j+1] <= v_q[j];
      f_valid_q <= v_q[LEVEL_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      from_q[0] <= ramp_i.from;
      up_q[0]   <= ramp_i.up;
      den_q[0]  <= ramp_i.den;
      rem_q[0]  <= prod[PROD_BITS-1:LEVEL_BITS];
      lo_q[0]   <= prod[LEVEL_BITS-1:0];
      for (int j = 0; j < LEVEL_BITS; j++) begin
        from_q[j+1] <= from_q[j];
        up_q[j+1]   <= up_q[j];
        rem_q[j+1]  <= rem_d[j];
        q_q[j+1]    <= q_d[j];
      end
      for (int j = 0; j < LEVEL_BITS - 1; j++) begin
        den_q[j+1] <= den_q[j];
        lo_q[j+1]  <= lo_q[j];
      end
      f_level_q <= up_q[LEVEL_BITS] ? from_q[LEVEL_BITS] + q_q[LEVEL_BITS]
                                    : from_q[LEVEL_BITS] - q_q[LEVEL_BITS];
    end
  end

  assign lvl_o.valid = f_valid_q;
  assign lvl_o.level = f_level_q;

endmodule

/* rtl/pwe_out_skid.sv */
`timescale 1ns / 1ps
// Output register with a one-entry skid stage that parts the pipeline from the sink.
// Depends on pwe_pkg for the level record.
module pwe_out_skid import pwe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pwe_lvl_t              lvl_i,
  output logic                  en_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [LEVEL_BITS-1:0] level_o
);

  logic                  out_v_d, out_v_q, skid_v_d, skid_v_q;
  logic [LEVEL_BITS-1:0] out_d, out_q, skid_d, skid_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (m_tready_i) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (!out_v_q || m_tready_i) begin
      out_v_d = lvl_i.valid;
      out_d   = lvl_i.level;
    end else if (lvl_i.valid) begin
      skid_v_d = 1'b1;
      skid_d   = lvl_i.level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign en_o       = ~skid_v_q;
  assign m_tvalid_o = out_v_q;
  assign level_o    = out_q;

endmodule

/* rtl/pulse_waveform_eval.sv */
`timescale 1ns / 1ps
// Top level of the trapezoidal pulse source evaluator.
// Depends on pwe_pkg and on pwe_cfg_regs, pwe_fold_pipe, pwe_seg_pipe,
// pwe_ramp_div_pipe and pwe_out_skid.
//
// Usage:
//   The slave stream carries one request per time value (s_tdata_i holds
//   time_now in ticks); the master stream returns one signed Q16.16 level
//   per request, in request order. The seven pulse registers are written
//   through cfg_we_i / cfg_idx_i / cfg_data_i while no request is in flight.
//   Throughput is one request per cycle while the skid register is empty.
//   The pipeline depth is set by the bit-serial period fold (one stage per
//   time bit) and the bit-serial ramp divider (one stage per level bit),
//   plus entry, two segment stages, the multiply stage, the final add and
//   the output register.
//   Reset clears the configuration and all valid flags and empties the pipeline.
//   When the receiver stalls, one more result is caught in a skid register
//   and s_tready_o then drops until the receiver takes a result; nothing in
//   the pipeline is lost or repeated.
module pulse_waveform_eval import pwe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Request stream. s_tdata_i fields from bit 0: time_now.
  input  logic                     s_tvalid_i,
  output logic                     s_tready_o,
  input  logic [S_DATA_BITS-1:0]   s_tdata_i,
  // Result stream. m_tdata_o fields from bit 0: level.
  output logic                     m_tvalid_o,
  input  logic                     m_tready_i,
  output logic [M_DATA_BITS-1:0]   m_tdata_o,
  // Configuration write port.
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  pwe_cfg_t              cfg;
  pwe_tau_t              tau;
  pwe_ramp_t             ramp;
  pwe_lvl_t              lvl;
  logic                  en;
  logic [LEVEL_BITS-1:0] level;

  pwe_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // All stages advance together while the skid register is empty.
  pwe_fold_pipe u_fold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (s_tvalid_i),
    .time_i     (s_tdata_i[TIME_BITS-1:0]),
    .cfg_i      (cfg),
    .tau_o      (tau)
  );

  pwe_seg_pipe u_seg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg),
    .tau_i  (tau),
    .ramp_o (ramp)
  );

  pwe_ramp_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ramp_i (ramp),
    .lvl_o  (lvl)
  );

  pwe_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lvl_i      (lvl),
    .en_o       (en),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .level_o    (level)
  );

  assign s_tready_o = en;
  assign m_tdata_o  = M_DATA_BITS'(level);

`ifndef SYNTHESIS
  // A full skid register always sits behind a shown result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o)
    else $error("skid holds a result while the output register is empty");

  // The pipeline only stops after the receiver refused a shown result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_tready_o) |-> $past(m_tvalid_o && !m_tready_i))
    else $error("pipeline stalled without a refused result");

  // A taken result drains the skid register by the next cycle.
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_tready_o && m_tready_i) |=> s_tready_o)
    else $error("skid register did not drain after the result was taken");
`endif

endmodule
